FILE: sv/height_profile_decimator_trace_macros.svh
// Assertion macros shared by the height profile decimator RTL.
`ifndef HEIGHT_PROFILE_DECIMATOR_TRACE_MACROS_SVH
`define HEIGHT_PROFILE_DECIMATOR_TRACE_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define HPDT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpdt: implication check failed");

// next-cycle implication
`define HPDT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpdt: next-cycle check failed");

`endif

FILE: sv/hpdt_pkg.sv
// Shared types and constants of the height profile decimator.
`default_nettype none
package hpdt_pkg;

	localparam int unsigned MAX_COLUMNS = 320;

	localparam logic [3:0] TRACE_COLOR = 4'd7;
	localparam logic [3:0] SKY_COLOR   = 4'd11;

	localparam logic [1:0] CFG_SAMPLES_PER_COLUMN = 2'd0;
	localparam logic [1:0] CFG_HEIGHT_DIVISOR     = 2'd1;
	localparam logic [1:0] CFG_NUM_COLUMNS        = 2'd2;
	localparam logic [1:0] CFG_SCREEN_X_ORIGIN    = 2'd3;

	localparam logic [6:0] RST_SAMPLES_PER_COLUMN = 7'd19;
	localparam logic [6:0] RST_HEIGHT_DIVISOR     = 7'd13;
	localparam logic [8:0] RST_NUM_COLUMNS        = 9'd158;
	localparam logic [9:0] RST_SCREEN_X_ORIGIN    = 10'd80;

	typedef struct packed {
		logic [6:0] samples_per_column;
		logic [6:0] height_divisor;
		logic [8:0] num_columns;
		logic [9:0] screen_x_origin;
	} cfg_t;

	// one finished column, handed from front to back
	typedef struct packed {
		logic [7:0] peak;
		logic [9:0] x;
		logic       clr;
	} job_t;

	typedef struct packed {
		logic [9:0] x;
		logic [5:0] y;
		logic [3:0] color;
		logic       last;
	} pix_t;

endpackage
`default_nettype wire

FILE: sv/height_profile_decimator_trace.sv
// Top level of the height profile decimator with line trace.
// Usage:
//   Samples enter through push/full; a sample transfers on a clock edge with
//   push high and full low; samples_per_column (1..64) samples close a column.
//   Pixels leave through empty/pop; the oldest pixel sits on the pixel ports
//   while empty is low and transfers on an edge with pop high.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write only while the block is idle.
// Flow:
//   A sample that does not close a column only updates the front's column
//   state. A column job passes a two-entry job queue to the back, which takes
//   it in IDLE, runs the 8-bit restoring divider in DIV, sets up in SETUP and
//   then writes one pixel per cycle while its pixel queue has room:
//   |new - previous| trace pixels (one if equal) plus the sky pixel. The
//   back loop is the rate limit; full rises while both job entries wait.
//   The first pixel of a column is written in TRACE, after IDLE, DIV and SETUP.
// Reset: arst_n low clears column state, both queues and the previous height,
//   and loads the default register values.
// Stall: with pop low the two-entry pixel queue fills, the back halts, then
//   the job queue fills and full holds off further samples. Nothing is lost.
`default_nettype none
`include "height_profile_decimator_trace_macros.svh"
module height_profile_decimator_trace (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] ground_height,
	input  wire logic       start_of_map,
	output logic            empty,
	input  wire logic       pop,
	output logic [9:0]      pixel_x,
	output logic [5:0]      pixel_y,
	output logic [3:0]      pixel_color,
	output logic            last_of_run,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [9:0] cfg_data
);

	hpdt_pkg::cfg_t cfg_q;
	hpdt_pkg::job_t job_in;
	hpdt_pkg::job_t job_out;
	hpdt_pkg::pix_t pix;
	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_empty;
	logic take;

	assign cfg_ready = 1'b1;
	assign full      = job_full;
	assign take      = push && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_column <= hpdt_pkg::RST_SAMPLES_PER_COLUMN;
			cfg_q.height_divisor     <= hpdt_pkg::RST_HEIGHT_DIVISOR;
			cfg_q.num_columns        <= hpdt_pkg::RST_NUM_COLUMNS;
			cfg_q.screen_x_origin    <= hpdt_pkg::RST_SCREEN_X_ORIGIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hpdt_pkg::CFG_SAMPLES_PER_COLUMN: cfg_q.samples_per_column <= cfg_data[6:0];
				hpdt_pkg::CFG_HEIGHT_DIVISOR:     cfg_q.height_divisor     <= cfg_data[6:0];
				hpdt_pkg::CFG_NUM_COLUMNS:        cfg_q.num_columns        <= cfg_data[8:0];
				hpdt_pkg::CFG_SCREEN_X_ORIGIN:    cfg_q.screen_x_origin    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hpdt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.take          (take),
		.ground_height (ground_height),
		.start_of_map  (start_of_map),
		.job           (job_in),
		.job_push      (job_push)
	);

	hpdt_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (job_out),
		.empty     (job_empty)
	);

	hpdt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.height_divisor (cfg_q.height_divisor),
		.job            (job_out),
		.job_empty      (job_empty),
		.job_pop        (job_pop),
		.empty          (empty),
		.pop            (pop),
		.pix            (pix)
	);

	assign pixel_x     = pix.x;
	assign pixel_y     = pix.y;
	assign pixel_color = pix.color;
	assign last_of_run = pix.last;

	// sky pixel closes a column at row zero
	`HPDT_ASSERT_IMP(a_sky_closes, !empty && pixel_color == hpdt_pkg::SKY_COLOR,
		last_of_run && pixel_y == 6'd0)
	`HPDT_ASSERT_IMP(a_trace_not_last, !empty && pixel_color == hpdt_pkg::TRACE_COLOR,
		!last_of_run)
	// a pushed job is waiting for the back on the next cycle
	`HPDT_ASSERT_NXT(a_job_kept, job_push && !job_full, !job_empty)

endmodule
`default_nettype wire

FILE: sv/hpdt_front.sv
// Front: takes samples, keeps the running column maximum, issues column jobs.
`default_nettype none
module hpdt_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hpdt_pkg::cfg_t cfg,
	input  wire logic          take,
	input  wire logic [7:0]    ground_height,
	input  wire logic          start_of_map,
	output hpdt_pkg::job_t     job,
	output logic               job_push
);

	logic [7:0] max_q;
	logic [5:0] sic_q;
	logic [8:0] cols_q;
	logic       pend_clr_q;

	logic [7:0] max_eff;
	logic [5:0] sic_eff;
	logic [8:0] cols_eff;
	logic [8:0] limit;
	logic [6:0] spc;
	logic [7:0] new_max;
	logic       active;
	logic       col_end;

	always_comb begin
		max_eff  = start_of_map ? 8'd0 : max_q;
		sic_eff  = start_of_map ? 6'd0 : sic_q;
		cols_eff = start_of_map ? 9'd0 : cols_q;
		limit = (cfg.num_columns > 9'(hpdt_pkg::MAX_COLUMNS)) ?
			9'(hpdt_pkg::MAX_COLUMNS) : cfg.num_columns;
		if (cfg.samples_per_column == 7'd0) begin
			spc = 7'd1;
		end else if (cfg.samples_per_column > 7'd64) begin
			spc = 7'd64;
		end else begin
			spc = cfg.samples_per_column;
		end
		active  = cols_eff < limit;
		new_max = (sic_eff == 6'd0 || ground_height > max_eff) ? ground_height : max_eff;
		col_end = ({1'b0, sic_eff} + 7'd1) >= spc;
		job_push = take && active && col_end;
		job.peak = new_max;
		job.x    = cfg.screen_x_origin + {1'b0, cols_eff};
		job.clr  = pend_clr_q | start_of_map;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= '0;
			sic_q      <= '0;
			cols_q     <= '0;
			pend_clr_q <= 1'b0;
		end else if (take) begin
			if (!active) begin
				max_q      <= max_eff;
				sic_q      <= sic_eff;
				cols_q     <= cols_eff;
				pend_clr_q <= pend_clr_q | start_of_map;
			end else if (!col_end) begin
				max_q      <= new_max;
				sic_q      <= sic_eff + 6'd1;
				cols_q     <= cols_eff;
				pend_clr_q <= pend_clr_q | start_of_map;
			end else begin
				// back starts from height zero, not the previous height, when the job carries clr
				max_q      <= '0;
				sic_q      <= '0;
				cols_q     <= cols_eff + 9'd1;
				pend_clr_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/hpdt_jobq.sv
// Two-entry job queue between front and back.
`default_nettype none
module hpdt_jobq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire hpdt_pkg::job_t push_data,
	output logic                full,
	input  wire logic           pop,
	output hpdt_pkg::job_t      pop_data,
	output logic                empty
);

	hpdt_pkg::job_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

FILE: sv/hpdt_back.sv
// Back: divides the column peak, walks the trace and queues the pixels.
`default_nettype none
module hpdt_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [6:0]     height_divisor,
	input  wire hpdt_pkg::job_t job,
	input  wire logic           job_empty,
	output logic                job_pop,
	output logic                empty,
	input  wire logic           pop,
	output hpdt_pkg::pix_t      pix
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_TRACE = 3'd3;
	localparam logic [2:0] ST_SKY   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] step_q;
	logic [6:0] rem_q;
	logic [7:0] quo_q;
	logic [9:0] x_q;
	logic       clr_q;
	logic [5:0] prev_q;
	logic [5:0] h_q;
	logic [5:0] cur_q;
	logic       up_q;

	// output queue
	hpdt_pkg::pix_t oq_q [2];
	logic       oq_wp_q;
	logic       oq_rp_q;
	logic [1:0] oq_cnt_q;
	logic       oq_full;
	logic       oq_wr;
	logic       oq_rd;
	hpdt_pkg::pix_t oq_din;

	logic [7:0] div;
	logic [7:0] trial;
	logic       fits;
	logic [5:0] h_sat;
	logic [5:0] y0;

	always_comb begin
		div   = (height_divisor == 7'd0) ? 8'd1 : {1'b0, height_divisor};
		trial = {rem_q, quo_q[7]};
		fits  = trial >= div;
		h_sat = (quo_q[7:6] != 2'b00) ? 6'd63 : quo_q[5:0];
		y0    = clr_q ? 6'd0 : prev_q;
		job_pop = (state_q == ST_IDLE) && !job_empty;
		oq_full = oq_cnt_q == 2'd2;
		oq_wr   = !oq_full && (state_q == ST_TRACE || state_q == ST_SKY);
		oq_rd   = pop && !empty;
		oq_din.x = x_q;
		if (state_q == ST_SKY) begin
			oq_din.y     = 6'd0;
			oq_din.color = hpdt_pkg::SKY_COLOR;
			oq_din.last  = 1'b1;
		end else begin
			oq_din.y     = cur_q;
			oq_din.color = hpdt_pkg::TRACE_COLOR;
			oq_din.last  = 1'b0;
		end
	end

	assign empty = oq_cnt_q == 2'd0;
	assign pix   = oq_q[oq_rp_q];

	always_ff @(posedge clk) begin
		if (oq_wr) begin
			oq_q[oq_wp_q] <= oq_din;
		end
		case (state_q)
			ST_IDLE: begin
				quo_q <= job.peak;
				rem_q <= '0;
				x_q   <= job.x;
				clr_q <= job.clr;
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				rem_q <= fits ? 7'(trial - div) : trial[6:0];
				quo_q <= {quo_q[6:0], fits};
			end
			ST_SETUP: begin
				h_q  <= h_sat;
				up_q <= h_sat > y0;
				if (h_sat == y0) begin
					cur_q <= h_sat;
				end else if (h_sat > y0) begin
					cur_q <= y0 + 6'd1;
				end else begin
					cur_q <= y0 - 6'd1;
				end
			end
			ST_TRACE: begin
				if (oq_wr) begin
					cur_q <= up_q ? cur_q + 6'd1 : cur_q - 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			prev_q   <= '0;
			oq_wp_q  <= 1'b0;
			oq_rp_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_wr) begin
				oq_wp_q <= ~oq_wp_q;
			end
			if (oq_rd) begin
				oq_rp_q <= ~oq_rp_q;
			end
			oq_cnt_q <= oq_cnt_q + {1'b0, oq_wr} - {1'b0, oq_rd};
			case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_TRACE;
				end
				ST_TRACE: begin
					if (oq_wr && cur_q == h_q) begin
						state_q <= ST_SKY;
					end
				end
				ST_SKY: begin
					if (oq_wr) begin
						prev_q  <= h_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
